// ===== src/pfaq_pkg.sv =====
// ----------------------------------------------------------------------------
// pfaq_pkg
// Shared constants, codes and types of the page frame allocator with quotas.
// ----------------------------------------------------------------------------
package pfaq_pkg;

    localparam int POOL_PAGES     = 32768;
    localparam int NUM_CONTAINERS = 4;
    localparam int PAGE_BITS      = 12;

    localparam int ADDR_W  = 32;
    localparam int PG_W    = ADDR_W - PAGE_BITS;          // page number of an address
    localparam int BASE_W  = PG_W + 1;                    // rounded-up page may carry
    localparam int IDX_W   = $clog2(POOL_PAGES);          // page index within the pool
    localparam int CNT_W   = $clog2(POOL_PAGES + 1);      // 0 .. POOL_PAGES
    localparam int FREE_W  = CNT_W + 1;                   // untouched + stacked
    localparam int FPAGE_W = 16;                          // free_pages field
    localparam int QUOTA_W = 21;
    localparam int CID_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_STOP  = 3'd1;
    localparam int                   CFG_QUOTA_BASE = 2;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_FREE = 2'd1,
        ST_QUOTA    = 2'd2,
        ST_NO_MEM   = 2'd3
    } t_status;

    // usage update sent to the quota unit
    typedef struct packed {
        logic             charge;
        logic             credit;
        logic [CID_W-1:0] id;
    } t_quota_upd;

endpackage

// ===== src/pfaq_stack_ram.sv =====
// ----------------------------------------------------------------------------
// pfaq_stack_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module pfaq_stack_ram #(
    parameter int DATA_W = 15,
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/pfaq_quota.sv =====
// ----------------------------------------------------------------------------
// pfaq_quota
// Per-container quota registers and page usage counters.
// ----------------------------------------------------------------------------
module pfaq_quota
    import pfaq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [QUOTA_W-1:0]   i_cfg_data,
    input  logic [CID_W-1:0]     i_cid,
    output logic                 o_over_quota,
    input  t_quota_upd           i_upd
);

    logic [QUOTA_W-1:0] r_quota [NUM_CONTAINERS];
    logic [QUOTA_W-1:0] r_usage [NUM_CONTAINERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CONTAINERS; k++) begin
                r_quota[k] <= '0;
            end
        end else if (i_cfg_wr) begin
            for (int k = 0; k < NUM_CONTAINERS; k++) begin
                if (i_cfg_index == CFG_IDX_W'(CFG_QUOTA_BASE + k)) begin
                    r_quota[k] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CONTAINERS; k++) begin
                r_usage[k] <= '0;
            end
        end else if (i_upd.charge) begin
            r_usage[i_upd.id] <= r_usage[i_upd.id] + QUOTA_W'(1);
        end else if (i_upd.credit && (r_usage[i_upd.id] != '0)) begin
            // never drop below zero
            r_usage[i_upd.id] <= r_usage[i_upd.id] - QUOTA_W'(1);
        end
    end

    assign o_over_quota = (r_usage[i_cid] >= r_quota[i_cid]);

endmodule

// ===== src/page_frame_allocator_quota_core.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_quota_core
// LIFO page frame allocator with per-container page quotas.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write pool_start, pool_stop and the four quotas through
//   the cfg channel (index 0..5) while the block is idle; o_cfg_ready is
//   always high. Pool registers act only at the next init request.
//   Requests (i_valid/o_ready) carry init, alloc or free. Each request gives
//   exactly one result on o_valid/i_ready: status, granted address and the
//   free page count after the operation.
//   The result is registered in the cycle after acceptance unless a stalled
//   receiver holds the output register. No new request is taken in the
//   execute stage, where an alloc uses the freed-page stack RAM read.
//   A finished result waits in the output register while the next request
//   is accepted; if the receiver stalls, the following request holds in the
//   execute stage until the output register frees.
//   Reset: pool empty, counters and container usage cleared, quotas zero;
//   the stack RAM is not cleared (only entries pushed since init are read).
// ----------------------------------------------------------------------------
module page_frame_allocator_quota_core
    import pfaq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    // request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [ADDR_W-1:0]    i_page_address,
    input  logic                 i_in_container,
    input  logic [CID_W-1:0]     i_container_id,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [ADDR_W-1:0]    o_granted_address,
    output logic [FPAGE_W-1:0]   o_free_pages
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state, n_state;
    logic                cfg_wr;
    logic                accept;
    logic                exec_go;

    // configured pool bounds, already in pages
    logic [BASE_W-1:0]   r_first_page;
    logic [PG_W-1:0]     r_last_page;

    // latched request
    logic [1:0]          r_cmd;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_charged;
    logic [CID_W-1:0]    r_cid;

    // pool state
    logic [BASE_W-1:0]   r_base, n_base;
    logic [CNT_W-1:0]    r_pool_size, n_pool_size;
    logic [CNT_W-1:0]    r_stack_cnt, n_stack_cnt;
    logic [CNT_W-1:0]    r_untouched, n_untouched;
    logic [FREE_W-1:0]   r_free_cnt, n_free_cnt;

    // result register
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [ADDR_W-1:0]   r_granted, n_granted;

    // stack RAM
    logic                ram_wr;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [IDX_W-1:0]    ram_wr_data;
    logic                ram_rd;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [IDX_W-1:0]    ram_rd_data;

    logic                over_quota;
    t_quota_upd          quota_upd;

    // datapath helpers
    logic [BASE_W-1:0]   span;
    logic [PG_W-1:0]     free_pg;
    logic [BASE_W-1:0]   free_off;
    logic                free_bad;
    logic [IDX_W-1:0]    untouched_idx;
    logic [IDX_W-1:0]    alloc_idx;
    logic [BASE_W-1:0]   alloc_pg;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || i_ready);

    // round pool start up to a page boundary at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= '0;
            r_last_page  <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_POOL_START) begin
                r_first_page <= BASE_W'(({1'b0, i_cfg_data}
                                + (ADDR_W + 1)'((1 << PAGE_BITS) - 1)) >> PAGE_BITS);
            end
            if (i_cfg_index == CFG_POOL_STOP) begin
                r_last_page <= i_cfg_data[ADDR_W-1:PAGE_BITS];
            end
        end
    end

    // start the stack-top read as the request is taken
    assign ram_rd      = accept && (i_cmd == CMD_ALLOC) && (r_stack_cnt != '0);
    assign ram_rd_addr = IDX_W'(r_stack_cnt - CNT_W'(1));

    pfaq_stack_ram #(
        .DATA_W (IDX_W),
        .ADDR_W (IDX_W)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    pfaq_quota u_quota (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (cfg_wr),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data[QUOTA_W-1:0]),
        .i_cid        (r_cid),
        .o_over_quota (over_quota),
        .i_upd        (quota_upd)
    );

    // free address check
    assign free_pg  = r_addr[ADDR_W-1:PAGE_BITS];
    assign free_off = {1'b0, free_pg} - r_base;
    assign free_bad = (r_addr[PAGE_BITS-1:0] != '0)
                   || ({1'b0, free_pg} < r_base)
                   || (free_off >= BASE_W'(r_pool_size))
                   || (r_stack_cnt >= CNT_W'(POOL_PAGES));

    assign span          = {1'b0, r_last_page} - r_first_page;
    assign untouched_idx = IDX_W'(r_untouched - CNT_W'(1));
    assign alloc_idx     = (r_stack_cnt != '0) ? ram_rd_data : untouched_idx;
    assign alloc_pg      = r_base + BASE_W'(alloc_idx);

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_pool_size = r_pool_size;
        n_stack_cnt = r_stack_cnt;
        n_untouched = r_untouched;
        n_free_cnt  = r_free_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_granted   = r_granted;
        ram_wr      = 1'b0;
        ram_wr_addr = IDX_W'(r_stack_cnt);
        ram_wr_data = IDX_W'(free_off);
        quota_upd   = '{charge: 1'b0, credit: 1'b0, id: r_cid};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_granted   = '0;
                    case (r_cmd)
                        CMD_INIT: begin
                            n_base      = r_first_page;
                            if ({1'b0, r_last_page} <= r_first_page) begin
                                n_pool_size = '0;
                            end else if (span > BASE_W'(POOL_PAGES)) begin
                                n_pool_size = CNT_W'(POOL_PAGES);
                            end else begin
                                n_pool_size = CNT_W'(span);
                            end
                            n_stack_cnt = '0;
                            n_untouched = n_pool_size;
                            n_free_cnt  = FREE_W'(n_pool_size);
                        end
                        CMD_ALLOC: begin
                            if (r_charged && over_quota) begin
                                n_status = ST_QUOTA;
                            end else if (r_stack_cnt == '0 && r_untouched == '0) begin
                                n_status = ST_NO_MEM;
                            end else begin
                                if (r_stack_cnt != '0) begin
                                    n_stack_cnt = r_stack_cnt - CNT_W'(1);
                                end else begin
                                    n_untouched = r_untouched - CNT_W'(1);
                                end
                                n_granted = {alloc_pg[PG_W-1:0], {PAGE_BITS{1'b0}}};
                                if (r_free_cnt != '0) begin
                                    n_free_cnt = r_free_cnt - FREE_W'(1);
                                end
                                quota_upd.charge = r_charged;
                            end
                        end
                        CMD_FREE: begin
                            if (free_bad) begin
                                n_status = ST_BAD_FREE;
                            end else begin
                                ram_wr           = 1'b1;
                                n_stack_cnt      = r_stack_cnt + CNT_W'(1);
                                n_free_cnt       = r_free_cnt + FREE_W'(1);
                                quota_upd.credit = r_charged;
                            end
                        end
                        default: begin
                            // unused command: report ok, change nothing
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_pool_size <= '0;
            r_stack_cnt <= '0;
            r_untouched <= '0;
            r_free_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_pool_size <= n_pool_size;
            r_stack_cnt <= n_stack_cnt;
            r_untouched <= n_untouched;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_granted   <= n_granted;
            // hold the request for the execute state
            if (accept) begin
                r_cmd     <= i_cmd;
                r_addr    <= i_page_address;
                r_charged <= i_in_container
                             && (int'(i_container_id) < NUM_CONTAINERS);
                r_cid     <= i_container_id;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_free_pages      = r_free_cnt[FPAGE_W-1:0];

endmodule
